@@ hw/rtl/shu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Selectable string hash package
// Shared algorithm codes, register indexes, constants and types.
// ----------------------------------------------------------------------------
package shu_pkg;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned ALG_W  = 4;

   localparam logic [ALG_W-1:0] ALG_NONE   = 4'd0;
   localparam logic [ALG_W-1:0] ALG_CRC32  = 4'd1;
   localparam logic [ALG_W-1:0] ALG_MURMUR = 4'd2;
   localparam logic [ALG_W-1:0] ALG_FNV    = 4'd3;
   localparam logic [ALG_W-1:0] ALG_OAAT   = 4'd4;
   localparam logic [ALG_W-1:0] ALG_DJB2   = 4'd5;
   localparam logic [ALG_W-1:0] ALG_KR31   = 4'd6;
   localparam logic [ALG_W-1:0] ALG_ROTXOR = 4'd7;
   localparam logic [ALG_W-1:0] ALG_X17    = 4'd8;

   localparam logic REG_ALGORITHM = 1'b0;
   localparam logic REG_SEED      = 1'b1;

   localparam logic [ALG_W-1:0]  ALG_RESET  = ALG_MURMUR;
   localparam logic [HASH_W-1:0] SEED_RESET = 32'h0000_0392;

   localparam logic [HASH_W-1:0] CRC_POLY    = 32'hEDB8_8320;
   localparam logic [HASH_W-1:0] CRC_INIT    = 32'hFFFF_FFFF;
   localparam logic [HASH_W-1:0] MURMUR_MULT = 32'h5BD1_E995;
   localparam logic [HASH_W-1:0] FNV_OFFSET  = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME   = 32'd16777619;
   localparam logic [HASH_W-1:0] DJB2_INIT   = 32'd5381;
   localparam logic [HASH_W-1:0] DJB2_MULT   = 32'd33;
   localparam logic [HASH_W-1:0] KR_MULT     = 32'd31;
   localparam logic [HASH_W-1:0] ROTXOR_INIT = 32'h5555_5555;
   localparam logic [HASH_W-1:0] X17_MULT    = 32'd17;
   localparam logic [HASH_W-1:0] X17_BIAS    = 32'd32;

   typedef struct packed {
      logic [ALG_W-1:0]  algorithm;
      logic [HASH_W-1:0] seed;
   } shu_cfg_type;

   typedef struct packed {
      logic        load;
      shu_cfg_type next;
   } shu_csr_ctl_type;

   function automatic logic [HASH_W-1:0] init_value(shu_cfg_type cfg);
      logic [HASH_W-1:0] v;
      case (cfg.algorithm)
         ALG_CRC32:  v = CRC_INIT;
         ALG_MURMUR: v = cfg.seed;
         ALG_FNV:    v = cfg.seed ^ FNV_OFFSET;
         ALG_DJB2:   v = DJB2_INIT;
         ALG_ROTXOR: v = ROTXOR_INIT;
         ALG_X17:    v = cfg.seed;
         default:    v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/shu_csr.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Selectable string hash registers
// APB-style register file holding the algorithm selector and the seed.
// ----------------------------------------------------------------------------
module shu_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [2:0]                 paddr,
   input  wire logic [31:0]                pwdata,
   output logic      [31:0]                prdata,
   output logic                            pready,
   output shu_pkg::shu_cfg_type            cfg,
   output shu_pkg::shu_csr_ctl_type        csr_ctl
);

   logic [shu_pkg::ALG_W-1:0]  algorithm_ff;
   logic [shu_pkg::ALG_W-1:0]  algorithm_in;
   logic [shu_pkg::HASH_W-1:0] seed_ff;
   logic [shu_pkg::HASH_W-1:0] seed_in;
   logic                       wr_en;
   logic                       reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[2];

   always_comb begin
      algorithm_in = algorithm_ff;
      seed_in      = seed_ff;
      if (wr_en) begin
         case (reg_index)
            shu_pkg::REG_ALGORITHM: algorithm_in = pwdata[shu_pkg::ALG_W-1:0];
            shu_pkg::REG_SEED:      seed_in      = pwdata;
            default:                ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         algorithm_ff <= shu_pkg::ALG_RESET;
         seed_ff      <= shu_pkg::SEED_RESET;
      end else begin
         algorithm_ff <= algorithm_in;
         seed_ff      <= seed_in;
      end
   end

   always_comb begin
      case (reg_index)
         shu_pkg::REG_ALGORITHM: prdata = {{(32-shu_pkg::ALG_W){1'b0}}, algorithm_ff};
         shu_pkg::REG_SEED:      prdata = seed_ff;
         default:                prdata = '0;
      endcase
   end

   assign cfg.algorithm            = algorithm_ff;
   assign cfg.seed                 = seed_ff;
   assign csr_ctl.load             = wr_en;
   assign csr_ctl.next.algorithm   = algorithm_in;
   assign csr_ctl.next.seed        = seed_in;

endmodule
`default_nettype wire

@@ hw/rtl/shu_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Selectable string hash core
// Running hash register with the per-byte update and the finishing step.
// ----------------------------------------------------------------------------
module shu_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire shu_pkg::shu_cfg_type         cfg,
   input  wire shu_pkg::shu_csr_ctl_type     csr_ctl,
   input  wire logic                         step,
   input  wire logic [7:0]                   data_byte,
   input  wire logic                         last_byte,
   output logic      [shu_pkg::HASH_W-1:0]   hash_value
);

   logic [shu_pkg::HASH_W-1:0] running_hash_ff;
   logic [shu_pkg::HASH_W-1:0] running_hash_in;
   logic [shu_pkg::HASH_W-1:0] ubyte;
   logic [shu_pkg::HASH_W-1:0] sbyte;
   logic [shu_pkg::HASH_W-1:0] upd_hash;
   logic [shu_pkg::HASH_W-1:0] init_hash;
   logic [shu_pkg::HASH_W-1:0] crc_acc;
   logic [shu_pkg::HASH_W-1:0] murmur_prod;
   logic [shu_pkg::HASH_W-1:0] oaat_acc;
   logic [shu_pkg::HASH_W-1:0] oaat_fin;
   logic [shu_pkg::HASH_W-1:0] rot_acc;

   assign ubyte     = {24'b0, data_byte};
   assign sbyte     = {{24{data_byte[7]}}, data_byte};
   assign init_hash = shu_pkg::init_value(cfg);

   always_comb begin
      crc_acc = running_hash_ff ^ ubyte;
      for (int j = 0; j < 8; j++) begin
         crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ shu_pkg::CRC_POLY) : (crc_acc >> 1);
      end
   end

   assign murmur_prod = (running_hash_ff ^ sbyte) * shu_pkg::MURMUR_MULT;
   assign oaat_acc    = running_hash_ff + sbyte;
   assign rot_acc     = running_hash_ff ^ sbyte;

   always_comb begin
      logic [shu_pkg::HASH_W-1:0] t;
      t = oaat_acc + (oaat_acc << 10);
      case (cfg.algorithm)
         shu_pkg::ALG_CRC32:  upd_hash = crc_acc;
         shu_pkg::ALG_MURMUR: upd_hash = murmur_prod ^ (murmur_prod >> 15);
         shu_pkg::ALG_FNV:    upd_hash = (running_hash_ff ^ ubyte) * shu_pkg::FNV_PRIME;
         shu_pkg::ALG_OAAT:   upd_hash = t ^ (t >> 6);
         shu_pkg::ALG_DJB2:   upd_hash = running_hash_ff * shu_pkg::DJB2_MULT + ubyte;
         shu_pkg::ALG_KR31:   upd_hash = sbyte + running_hash_ff * shu_pkg::KR_MULT;
         shu_pkg::ALG_ROTXOR: upd_hash = {rot_acc[26:0], rot_acc[31:27]};
         shu_pkg::ALG_X17:    upd_hash = running_hash_ff * shu_pkg::X17_MULT
                                         + (ubyte - shu_pkg::X17_BIAS);
         default:             upd_hash = '0;
      endcase
   end

   always_comb begin
      logic [shu_pkg::HASH_W-1:0] f;
      f        = upd_hash + (upd_hash << 3);
      f        = f ^ (f >> 11);
      oaat_fin = f + (f << 15);
   end

   always_comb begin
      case (cfg.algorithm)
         shu_pkg::ALG_CRC32:  hash_value = ~upd_hash;
         shu_pkg::ALG_OAAT:   hash_value = oaat_fin;
         shu_pkg::ALG_X17:    hash_value = upd_hash ^ (upd_hash >> 16);
         shu_pkg::ALG_MURMUR,
         shu_pkg::ALG_FNV,
         shu_pkg::ALG_DJB2,
         shu_pkg::ALG_KR31,
         shu_pkg::ALG_ROTXOR: hash_value = upd_hash;
         default:             hash_value = '0;
      endcase
   end

   always_comb begin
      running_hash_in = running_hash_ff;
      if (csr_ctl.load) begin
         running_hash_in = shu_pkg::init_value(csr_ctl.next);
      end else if (step) begin
         running_hash_in = last_byte ? init_hash : upd_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= shu_pkg::init_value('{algorithm: shu_pkg::ALG_RESET,
                                                   seed: shu_pkg::SEED_RESET});
      end else begin
         running_hash_ff <= running_hash_in;
      end
   end

   // A finished string leaves the running hash at the selected initial value.
   a_reload_after_last: assert property (@(posedge clock) disable iff (reset)
      (step && last_byte && !csr_ctl.load) |=> running_hash_ff == $past(init_hash))
      else $error("running hash not reloaded after the last byte");

   // An unused selector keeps the running hash at zero.
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      (cfg.algorithm == shu_pkg::ALG_NONE || cfg.algorithm > shu_pkg::ALG_X17)
      |-> running_hash_ff == '0)
      else $error("running hash nonzero with no algorithm selected");

   // A register write always reloads the running hash.
   a_reload_on_write: assert property (@(posedge clock) disable iff (reset)
      csr_ctl.load |=> running_hash_ff == shu_pkg::init_value(cfg))
      else $error("running hash not reloaded after a register write");

endmodule
`default_nettype wire

@@ hw/rtl/selectable_string_hash_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Selectable string hash unit
// Hashes key strings delivered one byte per word with one of eight hashes.
// ----------------------------------------------------------------------------
// The request channel carries one byte of a key string per word, with
// req_last_byte set on the final byte. Only the final byte produces a word on
// the response channel, holding the finished 32-bit hash of the string.
// Each byte is registered on acceptance and then folded into the running
// hash, and the finished hash of a last byte is registered in the response
// register. One byte is taken every cycle while no last byte stalls; the
// throughput is set by the update loop through the running hash register.
// The response register is separate from the input register, so bytes that
// do not end a string keep flowing while a response waits. Only a last byte
// stalls while the receiver holds rsp_ready low with a response pending.
// Reset selects the Murmur-style hash with seed 0x392 and loads the running
// hash with its initial value. Writing either register reloads the running
// hash; users must write registers only while the unit is idle, unenforced.
// ----------------------------------------------------------------------------
module selectable_string_hash_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_hash_value,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   shu_pkg::shu_cfg_type     cfg;
   shu_pkg::shu_csr_ctl_type csr_ctl;

   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [7:0]                 in_byte_ff;
   logic [7:0]                 in_byte_in;
   logic                       in_last_ff;
   logic                       in_last_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [shu_pkg::HASH_W-1:0] rsp_hash_ff;
   logic [shu_pkg::HASH_W-1:0] rsp_hash_in;
   logic [shu_pkg::HASH_W-1:0] core_hash;
   logic                       advance;
   logic                       req_accept;

   shu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .csr_ctl (csr_ctl)
   );

   shu_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .csr_ctl    (csr_ctl),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .hash_value (core_hash)
   );

   assign advance    = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_last_in  = req_last_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_hash_in  = core_hash;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         in_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         in_last_ff   <= in_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   // A new response only appears after a last byte has passed the hash stage.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("response raised without a last byte");

   // A held input word is neither dropped nor overwritten.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)
                                     && $stable(in_last_ff)))
      else $error("input register lost a pending word");

   // A pending response is never overwritten by the next string.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(advance && in_last_ff))
      else $error("response overwritten while stalled");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selectable string hash unit testbench
// Streams key strings a byte per word through the unit under every hash
// selector and several seeds. A local hash model predicts each finished
// hash, and every response word is checked against it in order. The run
// also covers idle and stall patterns and register writes on partial strings.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [2:0] ADDR_ALG  = {shu_pkg::REG_ALGORITHM, 2'b00};
   localparam logic [2:0] ADDR_SEED = {shu_pkg::REG_SEED, 2'b00};
   localparam logic [shu_pkg::ALG_W-1:0] ALG_UNUSED_LO = 4'd9;
   localparam logic [shu_pkg::ALG_W-1:0] ALG_UNUSED_HI = 4'd15;
   localparam int HOLD_OFF = 6;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } key_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_hash_value;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   key_byte_type               key_byte_q[$];
   logic [shu_pkg::HASH_W-1:0] expected_hash_q[$];
   key_byte_type               next_key_byte;
   logic [shu_pkg::ALG_W-1:0]  model_alg;
   logic [shu_pkg::HASH_W-1:0] model_seed;
   logic [shu_pkg::HASH_W-1:0] model_hash;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int err_count = 0;
   int bytes_sent = 0;
   int hashes_checked = 0;
   int settings_used = 0;

   selectable_string_hash_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [shu_pkg::HASH_W-1:0] hash_start(
      logic [shu_pkg::ALG_W-1:0] alg, logic [shu_pkg::HASH_W-1:0] sd);
      case (alg)
         shu_pkg::ALG_CRC32:  return shu_pkg::CRC_INIT;
         shu_pkg::ALG_MURMUR: return sd;
         shu_pkg::ALG_FNV:    return sd ^ shu_pkg::FNV_OFFSET;
         shu_pkg::ALG_DJB2:   return shu_pkg::DJB2_INIT;
         shu_pkg::ALG_ROTXOR: return shu_pkg::ROTXOR_INIT;
         shu_pkg::ALG_X17:    return sd;
         default:             return '0;
      endcase
   endfunction

   function automatic logic [shu_pkg::HASH_W-1:0] hash_step(
      logic [shu_pkg::ALG_W-1:0] alg, logic [shu_pkg::HASH_W-1:0] h, logic [7:0] b);
      logic [shu_pkg::HASH_W-1:0] ub;
      logic [shu_pkg::HASH_W-1:0] sb;
      logic [shu_pkg::HASH_W-1:0] t;
      int i;
      ub = {24'd0, b};
      sb = {{24{b[7]}}, b};
      case (alg)
         shu_pkg::ALG_CRC32: begin
            t = h ^ ub;
            for (i = 0; i < 8; i++)
               t = (t >> 1) ^ (t[0] ? shu_pkg::CRC_POLY : '0);
         end
         shu_pkg::ALG_MURMUR: begin
            t = (h ^ sb) * shu_pkg::MURMUR_MULT;
            t = t ^ (t >> 15);
         end
         shu_pkg::ALG_FNV: t = (h ^ ub) * shu_pkg::FNV_PRIME;
         shu_pkg::ALG_OAAT: begin
            t = h + sb;
            t = t + (t << 10);
            t = t ^ (t >> 6);
         end
         shu_pkg::ALG_DJB2:   t = h * shu_pkg::DJB2_MULT + ub;
         shu_pkg::ALG_KR31:   t = sb + shu_pkg::KR_MULT * h;
         shu_pkg::ALG_ROTXOR: begin
            t = h ^ sb;
            t = {t[26:0], t[31:27]};
         end
         shu_pkg::ALG_X17:    t = shu_pkg::X17_MULT * h + ub - shu_pkg::X17_BIAS;
         default:             t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [shu_pkg::HASH_W-1:0] hash_finish(
      logic [shu_pkg::ALG_W-1:0] alg, logic [shu_pkg::HASH_W-1:0] h);
      logic [shu_pkg::HASH_W-1:0] t;
      case (alg)
         shu_pkg::ALG_CRC32: t = ~h;
         shu_pkg::ALG_OAAT: begin
            t = h + (h << 3);
            t = t ^ (t >> 11);
            t = t + (t << 15);
         end
         shu_pkg::ALG_X17: t = h ^ (h >> 16);
         shu_pkg::ALG_MURMUR, shu_pkg::ALG_FNV, shu_pkg::ALG_DJB2,
         shu_pkg::ALG_KR31, shu_pkg::ALG_ROTXOR: t = h;
         default: t = '0;
      endcase
      return t;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %08h, want %08h at %0t ns", what, got, want, $time);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            bytes_sent++;
            model_hash = hash_step(model_alg, model_hash, req_data_byte);
            if (req_last_byte) begin
               expected_hash_q.push_back(hash_finish(model_alg, model_hash));
               model_hash = hash_start(model_alg, model_seed);
            end
         end
         if (!req_valid || req_ready) begin
            if (key_byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_key_byte = key_byte_q.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_key_byte.data;
               req_last_byte <= next_key_byte.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hash_q.size() == 0) begin
               report_mismatch("hash word with no string pending", rsp_hash_value, '0);
            end else begin
               hashes_checked++;
               if (rsp_hash_value !== expected_hash_q[0])
                  report_mismatch("hash_value", rsp_hash_value, expected_hash_q[0]);
               void'(expected_hash_q.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic csr_write_check(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] want;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (addr == ADDR_ALG) begin
         model_alg = value[shu_pkg::ALG_W-1:0];
         want = {28'd0, model_alg};
      end else begin
         model_seed = value;
         want = model_seed;
      end
      model_hash = hash_start(model_alg, model_seed);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (prdata !== want)
         report_mismatch("register readback", prdata, want);
   endtask

   task automatic push_key(input logic [7:0] b, input logic last);
      key_byte_type kb;
      kb.data = b;
      kb.last = last;
      key_byte_q.push_back(kb);
   endtask

   function automatic logic [7:0] pick_byte();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'h7F;
         2: return 8'h80;
         3: return 8'hFF;
         default: return r[7:0];
      endcase
   endfunction

   task automatic push_strings(input int count, input bit leave_open);
      int left;
      int len;
      int k;
      left = count;
      while (left > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
         if (len > left)
            len = left;
         for (k = 0; k < len; k++)
            push_key(pick_byte(), (k == len - 1) && !(leave_open && left == len));
         left -= len;
      end
   endtask

   task automatic wait_quiet();
      while (key_byte_q.size() != 0 || req_valid || expected_hash_q.size() != 0)
         @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   initial begin
      logic [shu_pkg::ALG_W-1:0] dir_alg [10];
      logic [shu_pkg::ALG_W-1:0] alg_sel;
      logic [31:0]               seed_val;
      logic [31:0]               r;
      int p;
      int d;
      dir_alg = '{shu_pkg::ALG_CRC32, shu_pkg::ALG_MURMUR, shu_pkg::ALG_FNV,
                  shu_pkg::ALG_OAAT, shu_pkg::ALG_DJB2, shu_pkg::ALG_KR31,
                  shu_pkg::ALG_ROTXOR, shu_pkg::ALG_X17, shu_pkg::ALG_NONE,
                  ALG_UNUSED_LO};
      model_alg = shu_pkg::ALG_RESET;
      model_seed = shu_pkg::SEED_RESET;
      model_hash = hash_start(model_alg, model_seed);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      push_key(8'h00, 1'b0);
      push_key(8'h7F, 1'b0);
      push_key(8'h80, 1'b0);
      push_key(8'hFF, 1'b1);
      wait_quiet();
      csr_write_check(ADDR_SEED, 32'hFFFF_FFFF);
      for (d = 0; d < 10; d++) begin
         csr_write_check(ADDR_ALG, {28'd0, dir_alg[d]});
         settings_used++;
         push_key(8'hFF, 1'b0);
         push_key(8'h80, 1'b1);
         wait_quiet();
      end
      csr_write_check(ADDR_ALG, {28'd0, ALG_UNUSED_HI});

      for (p = 0; p < 18; p++) begin
         case ((p + p / 4) % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 83; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 83; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         r = $urandom;
         alg_sel = (p < 16) ? p[shu_pkg::ALG_W-1:0] : r[shu_pkg::ALG_W-1:0];
         case (p % 4)
            0: seed_val = '0;
            1: seed_val = 32'hFFFF_FFFF;
            2: seed_val = $urandom;
            default: seed_val = shu_pkg::SEED_RESET;
         endcase
         csr_write_check(ADDR_ALG, {r[31:shu_pkg::ALG_W], alg_sel});
         csr_write_check(ADDR_SEED, seed_val);
         settings_used++;
         push_strings(18, 1'b0);
         wait_quiet();
         push_strings(17, p % 3 == 1);
         wait_quiet();
      end

      $display("Sent %0d key bytes and checked %0d hash words over %0d register settings,",
               bytes_sent, hashes_checked, settings_used);
      $display("covering all selector codes, seed extremes, stalls and partial-string writes.");
      if (err_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timeout with %0d hash words outstanding.", expected_hash_q.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
